// File: rtl/nfes_pkg.sv
// Package for the nearest facing edge search block.
// Holds shared constants, direction and register codes, and the queue flag struct.
// No dependencies.
package nfes_pkg;

  localparam int COORD_BITS_DEF = 31;
  localparam int CFG_IDX_BITS   = 3;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_QUERY_START_X   = 3'd0,
    CFG_QUERY_START_Y   = 3'd1,
    CFG_QUERY_END_X     = 3'd2,
    CFG_QUERY_END_Y     = 3'd3,
    CFG_QUERY_DIRECTION = 3'd4
  } nfes_cfg_idx_t;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_TOP   = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_DOWN  = 3'd3,
    DIR_LEFT  = 3'd4
  } nfes_dir_t;

  localparam int FLAG_BITS = 3;

  typedef struct packed {
    logic pass_a;
    logic pass_b;
    logic set_end;
  } nfes_flags_t;

endpackage

// File: rtl/nfes_edge_test.sv
// Candidate test for one edge against the query: axis, strict overlap, facing side,
// and distance from the low ends. Depends on nfes_pkg.
module nfes_edge_test #(
  parameter int COORD_BITS = nfes_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] ax,
  input  logic [COORD_BITS-1:0] ay,
  input  logic [COORD_BITS-1:0] bx,
  input  logic [COORD_BITS-1:0] by,
  input  logic [COORD_BITS-1:0] q_lo_x,
  input  logic [COORD_BITS-1:0] q_lo_y,
  input  logic [COORD_BITS-1:0] q_hi_x,
  input  logic [COORD_BITS-1:0] q_hi_y,
  input  logic [2:0]            dir,
  output logic                  pass,
  output logic [COORD_BITS-1:0] distance
);
  import nfes_pkg::*;

  logic                  horiz, axis_ok, along_x, upward, a_lt_b;
  logic                  overlap, side;
  logic [COORD_BITS-1:0] elx, ely, ehx, ehy;
  logic [COORD_BITS-1:0] e_lo_al, e_hi_al, q_lo_al, q_hi_al, e_lo_ac, q_lo_ac;

  always_comb begin
    horiz = (ay == by);
    case (dir)
      DIR_TOP, DIR_DOWN: begin
        axis_ok = horiz;
        along_x = 1'b1;
      end
      DIR_RIGHT, DIR_LEFT: begin
        axis_ok = !horiz;
        along_x = 1'b0;
      end
      default: begin
        axis_ok = 1'b0;
        along_x = 1'b1;
      end
    endcase
    upward = (dir == DIR_TOP) || (dir == DIR_RIGHT);

    a_lt_b = ($signed(ax) < $signed(bx)) || ((ax == bx) && ($signed(ay) < $signed(by)));
    elx = a_lt_b ? ax : bx;
    ely = a_lt_b ? ay : by;
    ehx = a_lt_b ? bx : ax;
    ehy = a_lt_b ? by : ay;

    e_lo_al = along_x ? elx : ely;
    e_hi_al = along_x ? ehx : ehy;
    q_lo_al = along_x ? q_lo_x : q_lo_y;
    q_hi_al = along_x ? q_hi_x : q_hi_y;
    e_lo_ac = along_x ? ely : elx;
    q_lo_ac = along_x ? q_lo_y : q_lo_x;

    overlap  = ($signed(e_lo_al) < $signed(q_hi_al)) && ($signed(q_lo_al) < $signed(e_hi_al));
    side     = upward ? ($signed(e_lo_ac) > $signed(q_lo_ac))
                      : ($signed(e_lo_ac) < $signed(q_lo_ac));
    distance = upward ? (e_lo_ac - q_lo_ac) : (q_lo_ac - e_lo_ac);
    pass     = axis_ok && overlap && side;
  end

endmodule

// File: rtl/nfes_front.sv
// Front end: accepts vertices, tracks outline state, forms the edge and closing edge,
// and classifies both into one queue entry. Depends on nfes_pkg, nfes_edge_test.
module nfes_front #(
  parameter int COORD_BITS = nfes_pkg::COORD_BITS_DEF,
  localparam int ENTRY_W   = nfes_pkg::FLAG_BITS + 10 * COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] vx,
  input  logic [COORD_BITS-1:0] vy,
  input  logic                  first,
  input  logic                  last,
  input  logic                  set_end,
  input  logic [COORD_BITS-1:0] qsx,
  input  logic [COORD_BITS-1:0] qsy,
  input  logic [COORD_BITS-1:0] qex,
  input  logic [COORD_BITS-1:0] qey,
  input  logic [2:0]            dir,
  input  logic                  q_full,
  output logic                  push,
  output logic [ENTRY_W-1:0]    push_data
);
  import nfes_pkg::*;

  logic [COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [COORD_BITS-1:0] first_x_nxt, first_y_nxt, prev_x_nxt, prev_y_nxt;
  logic [COORD_BITS-1:0] fx, fy, q_lo_x, q_lo_y, q_hi_x, q_hi_y;
  logic [COORD_BITS-1:0] dist_a, dist_b;
  logic                  pass_a, pass_b, q_s_lt_e;
  nfes_flags_t           flags;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    q_s_lt_e = ($signed(qsx) < $signed(qex)) || ((qsx == qex) && ($signed(qsy) < $signed(qey)));
    q_lo_x   = q_s_lt_e ? qsx : qex;
    q_lo_y   = q_s_lt_e ? qsy : qey;
    q_hi_x   = q_s_lt_e ? qex : qsx;
    q_hi_y   = q_s_lt_e ? qey : qsy;
    fx       = first ? vx : first_x_r;
    fy       = first ? vy : first_y_r;
  end

  nfes_edge_test #(.COORD_BITS(COORD_BITS)) u_edge_a (
    .ax(prev_x_r), .ay(prev_y_r), .bx(vx), .by(vy),
    .q_lo_x(q_lo_x), .q_lo_y(q_lo_y), .q_hi_x(q_hi_x), .q_hi_y(q_hi_y),
    .dir(dir), .pass(pass_a), .distance(dist_a)
  );

  // closing edge back to the outline's first vertex
  nfes_edge_test #(.COORD_BITS(COORD_BITS)) u_edge_b (
    .ax(vx), .ay(vy), .bx(fx), .by(fy),
    .q_lo_x(q_lo_x), .q_lo_y(q_lo_y), .q_hi_x(q_hi_x), .q_hi_y(q_hi_y),
    .dir(dir), .pass(pass_b), .distance(dist_b)
  );

  always_comb begin
    flags.pass_a  = pass_a && !first;
    flags.pass_b  = pass_b && (last || set_end);
    flags.set_end = set_end;
    push_data = {flags, dist_a, dist_b,
                 prev_x_r, prev_y_r, vx, vy,
                 vx, vy, fx, fy};
  end

  always_comb begin
    first_x_nxt = first_x_r;
    first_y_nxt = first_y_r;
    prev_x_nxt  = prev_x_r;
    prev_y_nxt  = prev_y_r;
    if (push) begin
      first_x_nxt = fx;
      first_y_nxt = fy;
      prev_x_nxt  = vx;
      prev_y_nxt  = vy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
    end else begin
      first_x_r <= first_x_nxt;
      first_y_r <= first_y_nxt;
      prev_x_r  <= prev_x_nxt;
      prev_y_r  <= prev_y_nxt;
    end
  end

endmodule

// File: rtl/nfes_queue.sv
// Small register queue between front and back ends.
// Depends on nfes_pkg for the default depth.
module nfes_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = nfes_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/nfes_back.sv
// Back end: running minimum over classified edges and the result register.
// Depends on nfes_pkg.
module nfes_back #(
  parameter int COORD_BITS = nfes_pkg::COORD_BITS_DEF,
  localparam int ENTRY_W   = nfes_pkg::FLAG_BITS + 10 * COORD_BITS,
  localparam int RES_W     = 5 * COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  logic [ENTRY_W-1:0]    q_data,
  output logic                  pop,
  input  logic [COORD_BITS-1:0] qsx,
  input  logic [COORD_BITS-1:0] qsy,
  input  logic [COORD_BITS-1:0] qex,
  input  logic [COORD_BITS-1:0] qey,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [RES_W-1:0]      out_res
);
  import nfes_pkg::*;

  localparam int EDGE_W = 4 * COORD_BITS;
  localparam logic [COORD_BITS-1:0] DIST_MAX = '1;

  nfes_flags_t           flags;
  logic [COORD_BITS-1:0] dist_a, dist_b, bd1, bd2;
  logic [EDGE_W-1:0]     edge_a, edge_b, be1, be2;
  logic                  cand_a, cand_b, bv1, bv2;

  logic [COORD_BITS-1:0] best_dist_r, best_dist_nxt;
  logic [EDGE_W-1:0]     best_edge_r, best_edge_nxt;
  logic                  best_valid_r, best_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [RES_W-1:0]      out_res_r, out_res_nxt;

  assign {flags, dist_a, dist_b, edge_a, edge_b} = q_data;

  assign pop       = !q_empty && (!flags.set_end || !out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_res   = out_res_r;

  always_comb begin
    cand_a = flags.pass_a && (dist_a < best_dist_r);
    bd1    = cand_a ? dist_a : best_dist_r;
    be1    = cand_a ? edge_a : best_edge_r;
    bv1    = cand_a || best_valid_r;
    cand_b = flags.pass_b && (dist_b < bd1);
    bd2    = cand_b ? dist_b : bd1;
    be2    = cand_b ? edge_b : be1;
    bv2    = cand_b || bv1;
  end

  always_comb begin
    best_dist_nxt  = best_dist_r;
    best_edge_nxt  = best_edge_r;
    best_valid_nxt = best_valid_r;
    out_found_nxt  = out_found_r;
    out_res_nxt    = out_res_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (pop) begin
      if (flags.set_end) begin
        best_dist_nxt  = DIST_MAX;
        best_valid_nxt = 1'b0;
        out_valid_nxt  = 1'b1;
        out_found_nxt  = bv2;
        out_res_nxt    = bv2 ? {bd2, be2[COORD_BITS-1:0], be2[2*COORD_BITS-1:COORD_BITS],
                                 be2[3*COORD_BITS-1:2*COORD_BITS],
                                 be2[4*COORD_BITS-1:3*COORD_BITS]}
                             : {DIST_MAX, qey, qex, qsy, qsx};
      end else begin
        best_dist_nxt  = bd2;
        best_edge_nxt  = be2;
        best_valid_nxt = bv2;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_edge_r <= best_edge_nxt;
    out_found_r <= out_found_nxt;
    out_res_r   <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r  <= DIST_MAX;
      best_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      best_dist_r  <= best_dist_nxt;
      best_valid_r <= best_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/nearest_facing_edge_search_top.sv
// Top level of the nearest facing edge search: query registers, front end, queue, back end.
// Depends on nfes_pkg, nfes_front, nfes_queue, nfes_back.
//
// Vertices stream in at one per cycle while ready. The front end classifies the edge ending
// at each vertex and, where an outline or the set ends, the closing edge, both in the cycle
// of acceptance; a two-entry queue hands them to the back end, whose single running-minimum
// compare chain folds one entry per cycle. The result for a set appears in the output
// register after its final vertex is taken, and later vertices keep flowing while it waits.
// A stalled result holds the back end only when a second set ends behind it; the queue then
// fills and in_tready drops. Query registers must be written only while idle; unenforced.
module nearest_facing_edge_search_top #(
  parameter int  COORD_BITS = nfes_pkg::COORD_BITS_DEF,
  localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((5 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,   // vertex_x, vertex_y
  input  logic [1:0]                        in_tuser,   // outline_first, outline_last
  input  logic                              in_tlast,   // set_last
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // near_start_x, near_start_y, near_end_x, near_end_y, near_distance
  output logic [OUT_W-1:0]                  out_tdata,
  output logic                              out_tuser,  // found
  input  logic                              cfg_we,
  input  logic [nfes_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]             cfg_wdata
);
  import nfes_pkg::*;

  localparam int ENTRY_W = FLAG_BITS + 10 * COORD_BITS;

  logic [COORD_BITS-1:0] qsx_r, qsy_r, qex_r, qey_r;
  logic [2:0]            dir_r;
  logic                  push, pop, q_full, q_empty;
  logic [ENTRY_W-1:0]    push_data, pop_data;
  logic [5*COORD_BITS-1:0] res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qsx_r <= '0;
      qsy_r <= '0;
      qex_r <= '0;
      qey_r <= '0;
      dir_r <= DIR_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUERY_START_X:   qsx_r <= cfg_wdata;
        CFG_QUERY_START_Y:   qsy_r <= cfg_wdata;
        CFG_QUERY_END_X:     qex_r <= cfg_wdata;
        CFG_QUERY_END_Y:     qey_r <= cfg_wdata;
        CFG_QUERY_DIRECTION: dir_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  nfes_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .vx       (in_tdata[COORD_BITS-1:0]),
    .vy       (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .first    (in_tuser[0]),
    .last     (in_tuser[1]),
    .set_end  (in_tlast),
    .qsx      (qsx_r),
    .qsy      (qsy_r),
    .qex      (qex_r),
    .qey      (qey_r),
    .dir      (dir_r),
    .q_full   (q_full),
    .push     (push),
    .push_data(push_data)
  );

  nfes_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .full     (q_full),
    .empty    (q_empty)
  );

  nfes_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (pop_data),
    .pop      (pop),
    .qsx      (qsx_r),
    .qsy      (qsy_r),
    .qex      (qex_r),
    .qey      (qey_r),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_found(out_tuser),
    .out_res  (res)
  );

  assign out_tdata = OUT_W'(res);

endmodule

// File: rtl/nfes_checker.sv
// Port-level checks for the nearest facing edge search top level, with its bind.
// Depends on nearest_facing_edge_search_top.
module nfes_checker #(
  parameter int  COORD_BITS = nfes_pkg::COORD_BITS_DEF,
  localparam int OUT_W = ((5 * COORD_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser
);
  localparam logic [COORD_BITS-1:0] DIST_MAX = '1;

  logic [COORD_BITS-1:0] near_dist;
  assign near_dist = out_tdata[5*COORD_BITS-1:4*COORD_BITS];

  a_no_result_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_miss_distance: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> near_dist == DIST_MAX)
    else $error("query returned without maximum distance");

  a_hit_distance: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> near_dist != DIST_MAX)
    else $error("found edge at maximum distance");

endmodule

bind nearest_facing_edge_search_top nfes_checker #(.COORD_BITS(COORD_BITS)) u_nfes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
